>>> sv/pcw_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the
// panorama to cube map warp unit. No dependencies.
package pcw_pkg;

    localparam int DATA_W     = 36;       // CORDIC vector width, 24 fractional bits
    localparam int VEC_SHIFT  = 24;
    localparam int INV_GAIN   = 10188014; // 1/K in Q24
    localparam int LO_W       = 18;       // split point of the gain multiply
    localparam int COL_W      = 9;        // source column, up to 4 * 127
    localparam int ROW_W      = 8;        // source row, up to 2 * 127
    localparam int IDX_W      = 12;       // signed integer part of u and v
    localparam int PIX_W      = 24;
    localparam int WGT_W      = 17;

    // atan(2^-i) in turns, 32 fractional bits
    localparam logic [31:0] ATAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        FACE_TOP   = 3'd0,
        FACE_LEFT  = 3'd1,
        FACE_FRONT = 3'd2,
        FACE_RIGHT = 3'd3,
        FACE_BACK  = 3'd4,
        FACE_DOWN  = 3'd5
    } face_t;

    // transaction payload carried alongside the angle pipelines
    typedef struct packed
    {
        op_t                      op;
        logic signed [DATA_W-1:0] zc;
        logic [6:0]               bw;
        logic [7:0]               orow;
        logic [7:0]               ocol;
        logic [6:0]               sr;
        logic [7:0]               sc;
        logic [PIX_W-1:0]         rgb;
    } item_t;

    // request into the fetch and blend unit
    typedef struct packed
    {
        op_t              op;
        logic [COL_W-1:0] ua;
        logic [COL_W-1:0] ub;
        logic [ROW_W-1:0] va;
        logic [ROW_W-1:0] vb;
        logic [7:0]       mu;
        logic [7:0]       nu;
        logic [7:0]       orow;
        logic [7:0]       ocol;
        logic [6:0]       sr;
        logic [7:0]       sc;
        logic [PIX_W-1:0] rgb;
    } texel_req_t;

    // arctangent step rounded to frac_bits fractional bits of a turn
    function automatic logic [31:0] atan_step(input int idx, input int frac_bits);
        logic [32:0] e;
        e = {1'b0, ATAN_TURNS[idx]} + (33'd1 << (31 - frac_bits));
        return 32'(e >> (32 - frac_bits));
    endfunction

endpackage

>>> sv/panorama_to_cubemap_warp_unit.sv
// Top level of the panorama to cube map warp: cube point, two CORDIC
// pipelines, coordinate mapping and the fetch/blend unit.
// Depends on pcw_pkg, pcw_cordic, pcw_texel (and through it pcw_ram).
//
//   channel   signals                                   direction
//   input     in_valid, in_stall, operation .. in_red   in, in_stall out
//   output    out_valid, out_stall, out_row .. out_red  out, out_stall in
//   config    cfg_we, cfg_wdata (block_width)           in
//
// One transaction enters per cycle while the output is not stalled; most of the
// pipeline is the two pipelined CORDIC chains of one stage per
// iteration. Corners come from four row/column parity banks in one read.
// A stalled output freezes the whole pipeline, including the memory stage.
// Reset sets block_width to 64; the source store is not cleared.
module panorama_to_cubemap_warp_unit #(
    parameter int MAX_BLOCK_WIDTH = 64,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [2:0] face,
    input  logic [5:0] face_row,
    input  logic [5:0] face_col,
    input  logic [6:0] src_row,
    input  logic [7:0] src_col,
    input  logic [7:0] in_blue,
    input  logic [7:0] in_green,
    input  logic [7:0] in_red,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_row,
    output logic [7:0] out_col,
    output logic [7:0] out_blue,
    output logic [7:0] out_green,
    output logic [7:0] out_red,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata
);

    localparam int F      = ANGLE_FRAC_BITS;
    localparam int DW     = pcw_pkg::DATA_W;
    localparam int ZW     = F + 2;
    localparam int PW     = ZW + 10;
    localparam int UW     = ZW + 11;
    localparam int IW     = pcw_pkg::IDX_W;
    localparam int DROP   = F - 8;
    localparam int ITEM_W = $bits(pcw_pkg::item_t);
    localparam int SIDE2W = ZW + ITEM_W;
    localparam logic signed [UW-1:0] RND = UW'(2 ** (DROP - 1));

    logic adv;
    logic accept;

    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    // configuration
    logic [6:0] block_width_reg;
    logic [6:0] bw_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_width_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            block_width_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        bw_eff = block_width_reg;
        if (block_width_reg == 7'd0)
        begin
            bw_eff = 7'd1;
        end
        else if (32'(block_width_reg) > MAX_BLOCK_WIDTH)
        begin
            bw_eff = 7'(MAX_BLOCK_WIDTH);
        end
    end

    // cube point for the incoming transaction
    logic signed [8:0] pc;
    logic signed [8:0] qc;
    logic signed [8:0] bs;
    logic signed [8:0] cx;
    logic signed [8:0] cy;
    logic signed [8:0] cz;
    logic [7:0]        orow;
    logic [7:0]        ocol;
    logic              face_ok;
    logic              sample_ok;
    logic              write_ok;
    logic              c1_in_valid;
    pcw_pkg::item_t    in_item;

    assign pc = $signed({2'b00, face_row, 1'b0});
    assign qc = $signed({2'b00, face_col, 1'b0});
    assign bs = $signed({2'b00, bw_eff});

    always_comb
    begin
        cx      = '0;
        cy      = '0;
        cz      = '0;
        orow    = 8'(face_row);
        ocol    = 8'(face_col);
        face_ok = 1'b1;
        unique case (pcw_pkg::face_t'(face))
            pcw_pkg::FACE_TOP:
            begin
                cx   = pc - bs;
                cy   = qc - bs;
                cz   = bs;
                ocol = 8'(face_col) + 8'(bw_eff);
            end
            pcw_pkg::FACE_LEFT:
            begin
                cx   = qc - bs;
                cy   = -bs;
                cz   = bs - pc;
                orow = 8'(face_row) + 8'(bw_eff);
            end
            pcw_pkg::FACE_FRONT:
            begin
                cx   = bs;
                cy   = qc - bs;
                cz   = bs - pc;
                orow = 8'(face_row) + 8'(bw_eff);
                ocol = 8'(face_col) + 8'(bw_eff);
            end
            pcw_pkg::FACE_RIGHT:
            begin
                cx   = bs - qc;
                cy   = bs;
                cz   = bs - pc;
                orow = 8'(face_row) + 8'(bw_eff);
                ocol = 8'(face_col) + {bw_eff, 1'b0};
            end
            pcw_pkg::FACE_BACK:
            begin
                cx   = -bs;
                cy   = bs - qc;
                cz   = bs - pc;
                orow = 8'(face_row) + 8'(bw_eff);
                ocol = 8'(face_col) + 8'(bw_eff) + {bw_eff, 1'b0};
            end
            pcw_pkg::FACE_DOWN:
            begin
                cx   = bs - pc;
                cy   = qc - bs;
                cz   = -bs;
                orow = 8'(face_row) + {bw_eff, 1'b0};
                ocol = 8'(face_col) + 8'(bw_eff);
            end
            default:
            begin
                face_ok = 1'b0;
            end
        endcase
    end

    assign sample_ok = face_ok && ({1'b0, face_row} < bw_eff) && ({1'b0, face_col} < bw_eff);
    assign write_ok  = (32'(src_row) < 2 * MAX_BLOCK_WIDTH)
                       && (32'(src_col) < 4 * MAX_BLOCK_WIDTH);
    // drop bad samples and out-of-range writes
    assign c1_in_valid = accept && ((operation == pcw_pkg::OP_SAMPLE) ? sample_ok : write_ok);

    assign in_item.op   = pcw_pkg::op_t'(operation);
    assign in_item.zc   = {{3{cz[8]}}, cz, 24'd0};
    assign in_item.bw   = bw_eff;
    assign in_item.orow = orow;
    assign in_item.ocol = ocol;
    assign in_item.sr   = src_row;
    assign in_item.sc   = src_col;
    assign in_item.rgb  = {in_red, in_green, in_blue};

    // longitude
    logic                 c1_valid;
    logic signed [ZW-1:0] c1_angle;
    logic signed [DW-1:0] c1_mag;
    logic [ITEM_W-1:0]    c1_side;

    pcw_cordic #(
        .FRAC_BITS(F),
        .SIDE_W   (ITEM_W)
    ) u_cordic_lon (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (c1_in_valid),
        .in_x     ({{3{cx[8]}}, cx, 24'd0}),
        .in_y     ({{3{cy[8]}}, cy, 24'd0}),
        .in_side  (in_item),
        .out_valid(c1_valid),
        .out_angle(c1_angle),
        .out_mag  (c1_mag),
        .out_side (c1_side)
    );

    // gain correction, split into two partial products
    logic                 g1_valid_reg;
    logic [41:0]          g1_lo_reg;
    logic [41:0]          g1_hi_reg;
    logic signed [ZW-1:0] g1_t_reg;
    pcw_pkg::item_t       g1_item_reg;

    logic                 g2_valid_reg;
    logic signed [DW-1:0] g2_r_reg;
    logic signed [ZW-1:0] g2_t_reg;
    pcw_pkg::item_t       g2_item_reg;
    logic [59:0]          g_sum;

    assign g_sum = {g1_hi_reg, 18'd0} + 60'(g1_lo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            g1_valid_reg <= c1_valid;
            g2_valid_reg <= g1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_lo_reg   <= 42'(c1_mag[pcw_pkg::LO_W-1:0] * 24'(pcw_pkg::INV_GAIN));
            g1_hi_reg   <= 42'(c1_mag[DW-1:pcw_pkg::LO_W] * 24'(pcw_pkg::INV_GAIN));
            g1_t_reg    <= c1_angle;
            g1_item_reg <= c1_side;
            g2_r_reg    <= DW'(g_sum >> pcw_pkg::VEC_SHIFT);
            g2_t_reg    <= g1_t_reg;
            g2_item_reg <= g1_item_reg;
        end
    end

    // latitude
    logic                 c2_valid;
    logic signed [ZW-1:0] c2_angle;
    logic [SIDE2W-1:0]    c2_side;
    logic signed [ZW-1:0] c2_t;
    pcw_pkg::item_t       c2_item;

    pcw_cordic #(
        .FRAC_BITS(F),
        .SIDE_W   (SIDE2W)
    ) u_cordic_lat (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (g2_valid_reg),
        .in_x     (g2_r_reg),
        .in_y     (g2_item_reg.zc),
        .in_side  ({g2_t_reg, g2_item_reg}),
        .out_valid(c2_valid),
        .out_angle(c2_angle),
        .out_mag  (),
        .out_side (c2_side)
    );

    assign {c2_t, c2_item} = c2_side;

    // map angles to source coordinates
    logic                 m1_valid_reg;
    logic signed [PW-1:0] m1_pt_reg;
    logic signed [PW-1:0] m1_pp_reg;
    pcw_pkg::item_t       m1_item_reg;

    logic                 m2_valid_reg;
    logic signed [UW-1:0] m2_u8_reg;
    logic signed [UW-1:0] m2_v8_reg;
    pcw_pkg::item_t       m2_item_reg;

    logic                 m3_valid_reg;
    pcw_pkg::texel_req_t  m3_req_reg;

    logic [8:0]           b4;
    logic signed [UW-1:0] pt_ext;
    logic signed [UW-1:0] pp_ext;
    logic signed [UW-1:0] u_bias;
    logic signed [UW-1:0] v_bias;
    logic signed [UW-1:0] u8_next;
    logic signed [UW-1:0] v8_next;

    assign b4      = {c2_item.bw, 2'b00};
    assign pt_ext  = UW'(m1_pt_reg);
    assign pp_ext  = UW'(m1_pp_reg);
    assign u_bias  = UW'({m1_item_reg.bw, 1'b0}) << F;
    assign v_bias  = UW'(m1_item_reg.bw) << F;
    assign u8_next = (pt_ext + u_bias + RND) >>> DROP;
    assign v8_next = (v_bias - pp_ext + RND) >>> DROP;

    logic signed [IW-1:0]      ui;
    logic signed [IW-1:0]      vi;
    logic signed [IW-1:0]      vi1;
    logic signed [IW-1:0]      w_i;
    logic signed [IW-1:0]      h_i;
    logic signed [IW-1:0]      ua_i;
    logic [pcw_pkg::COL_W-1:0] ua;
    logic [pcw_pkg::COL_W-1:0] ua1;
    logic [pcw_pkg::COL_W-1:0] w9;
    pcw_pkg::texel_req_t       req_next;

    assign ui  = m2_u8_reg[8 +: IW];
    assign vi  = m2_v8_reg[8 +: IW];
    assign vi1 = vi + IW'(1);
    assign w9  = {m2_item_reg.bw, 2'b00};
    assign w_i = IW'(w9);
    assign h_i = IW'({m2_item_reg.bw, 1'b0});
    assign ua  = pcw_pkg::COL_W'(ua_i);
    assign ua1 = ua + pcw_pkg::COL_W'(1);

    always_comb
    begin
        // wrap columns, clamp rows
        if (ui < 0)
        begin
            ua_i = ui + w_i;
        end
        else if (ui >= w_i)
        begin
            ua_i = ui - w_i;
        end
        else
        begin
            ua_i = ui;
        end

        req_next.op   = m2_item_reg.op;
        req_next.ua   = ua;
        req_next.ub   = (ua1 == w9) ? '0 : ua1;
        if (vi < 0)
        begin
            req_next.va = '0;
        end
        else if (vi > h_i - IW'(1))
        begin
            req_next.va = pcw_pkg::ROW_W'(h_i - IW'(1));
        end
        else
        begin
            req_next.va = pcw_pkg::ROW_W'(vi);
        end
        if (vi1 < 0)
        begin
            req_next.vb = '0;
        end
        else if (vi1 > h_i - IW'(1))
        begin
            req_next.vb = pcw_pkg::ROW_W'(h_i - IW'(1));
        end
        else
        begin
            req_next.vb = pcw_pkg::ROW_W'(vi1);
        end
        req_next.mu   = m2_u8_reg[7:0];
        req_next.nu   = m2_v8_reg[7:0];
        req_next.orow = m2_item_reg.orow;
        req_next.ocol = m2_item_reg.ocol;
        req_next.sr   = m2_item_reg.sr;
        req_next.sc   = m2_item_reg.sc;
        req_next.rgb  = m2_item_reg.rgb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg <= c2_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_pt_reg   <= $signed({1'b0, b4}) * c2_t;
            m1_pp_reg   <= $signed({1'b0, b4}) * c2_angle;
            m1_item_reg <= c2_item;
            m2_u8_reg   <= u8_next;
            m2_v8_reg   <= v8_next;
            m2_item_reg <= m1_item_reg;
            m3_req_reg  <= req_next;
        end
    end

    pcw_texel #(
        .MAX_BLOCK_WIDTH(MAX_BLOCK_WIDTH)
    ) u_texel (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .req_valid(m3_valid_reg),
        .req      (m3_req_reg),
        .out_valid(out_valid),
        .out_row  (out_row),
        .out_col  (out_col),
        .out_blue (out_blue),
        .out_green(out_green),
        .out_red  (out_red)
    );

`ifndef SYNTH
    a_rows_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        m3_valid_reg && m3_req_reg.op == pcw_pkg::OP_SAMPLE
        |-> (m3_req_reg.vb == m3_req_reg.va) || (m3_req_reg.vb == m3_req_reg.va + 8'd1))
        else $error("corner rows not adjacent");
    a_cols_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        m3_valid_reg && m3_req_reg.op == pcw_pkg::OP_SAMPLE
        |-> (m3_req_reg.ub == m3_req_reg.ua + 9'd1) || (m3_req_reg.ub == 9'd0))
        else $error("corner columns not adjacent");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(m3_req_reg) && $stable(m3_valid_reg))
        else $error("pipeline moved while output stalled");
`endif

endmodule

>>> sv/pcw_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module pcw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/pcw_cordic.sv
// Pipelined vectoring CORDIC: one registered stage for the half-plane
// fold, then one registered stage per iteration. Depends on pcw_pkg.
module pcw_cordic #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic                             in_valid,
    input  logic signed [pcw_pkg::DATA_W-1:0] in_x,
    input  logic signed [pcw_pkg::DATA_W-1:0] in_y,
    input  logic [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    output logic signed [FRAC_BITS+1:0]      out_angle,
    output logic signed [pcw_pkg::DATA_W-1:0] out_mag,
    output logic [SIDE_W-1:0]                out_side
);

    localparam int DW = pcw_pkg::DATA_W;
    localparam int ZW = FRAC_BITS + 2;
    localparam int N  = FRAC_BITS;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(2 ** (FRAC_BITS - 2));

    logic signed [DW-1:0] x_reg    [N+1];
    logic signed [DW-1:0] y_reg    [N+1];
    logic signed [ZW-1:0] z_reg    [N+1];
    logic [SIDE_W-1:0]    side_reg [N+1];
    logic                 zero_reg [N+1];
    logic                 valid_reg[N+1];

    logic signed [DW-1:0] x0_next;
    logic signed [DW-1:0] y0_next;
    logic signed [ZW-1:0] z0_next;

    // fold the left half plane onto the right one
    always_comb
    begin
        x0_next = in_x;
        y0_next = in_y;
        z0_next = '0;
        if (in_x < 0)
        begin
            if (in_y >= 0)
            begin
                x0_next = in_y;
                y0_next = -in_x;
                z0_next = QUARTER;
            end
            else
            begin
                x0_next = -in_y;
                y0_next = in_x;
                z0_next = -QUARTER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            side_reg[0] <= in_side;
            zero_reg[0] <= (in_x == 0) && (in_y == 0);
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] STEP = ZW'(pcw_pkg::atan_step(i, FRAC_BITS));

        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [DW-1:0] x_next;
        logic signed [DW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_comb
        begin
            if (y_reg[i] >= 0)
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + STEP;
            end
            else
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - STEP;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                side_reg[i+1] <= side_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // a zero vector has angle and magnitude zero
    assign out_valid = valid_reg[N];
    assign out_angle = zero_reg[N] ? '0 : z_reg[N];
    assign out_mag   = zero_reg[N] ? '0 : x_reg[N];
    assign out_side  = side_reg[N];

`ifndef SYNTH
    a_mag_positive: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[N] && !zero_reg[N] |-> x_reg[N] > 0)
        else $error("cordic magnitude not positive for a nonzero vector");
`endif

endmodule

>>> sv/pcw_texel.sv
// Four-bank source image store, corner fetch and bilinear blend, ending
// in the output register. Depends on pcw_pkg and pcw_ram.
module pcw_texel #(
    parameter int MAX_BLOCK_WIDTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                req_valid,
    input  pcw_pkg::texel_req_t req,
    output logic                out_valid,
    output logic [7:0]          out_row,
    output logic [7:0]          out_col,
    output logic [7:0]          out_blue,
    output logic [7:0]          out_green,
    output logic [7:0]          out_red
);

    localparam int BANK_DEPTH = 2 * MAX_BLOCK_WIDTH * MAX_BLOCK_WIDTH;
    localparam int AW         = $clog2(BANK_DEPTH);
    localparam int ROW_PITCH  = 2 * MAX_BLOCK_WIDTH;
    localparam int PW         = pcw_pkg::PIX_W;
    localparam int WW         = pcw_pkg::WGT_W;
    localparam int MW         = 8 + WW;

    logic          sample;
    logic          rd_en;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_bank;
    logic [AW-1:0] rd_addr [4];
    logic [PW-1:0] rd_data [4];
    logic          bank_we [4];

    assign sample  = req_valid && (req.op == pcw_pkg::OP_SAMPLE);
    assign rd_en   = adv && sample;
    assign wr_bank = {req.sr[0], req.sc[0]};
    assign wr_addr = AW'(32'(req.sr >> 1) * ROW_PITCH + 32'(req.sc >> 1));

    // bank k holds rows of parity k[1] and columns of parity k[0]
    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        localparam logic RP = 1'(k / 2);
        localparam logic CP = 1'(k % 2);

        logic [pcw_pkg::ROW_W-1:0] row;
        logic [pcw_pkg::COL_W-1:0] col;

        assign row        = (req.va[0] == RP) ? req.va : req.vb;
        assign col        = (req.ua[0] == CP) ? req.ua : req.ub;
        assign rd_addr[k] = AW'(32'(row >> 1) * ROW_PITCH + 32'(col >> 1));
        assign bank_we[k] = adv && req_valid && (req.op == pcw_pkg::OP_WRITE)
                            && (wr_bank == 2'(k));

        pcw_ram #(
            .WIDTH(PW),
            .DEPTH(BANK_DEPTH)
        ) u_ram (
            .clk  (clk),
            .we   (bank_we[k]),
            .waddr(wr_addr),
            .wdata(req.rgb),
            .re   (rd_en),
            .raddr(rd_addr[k]),
            .rdata(rd_data[k])
        );
    end

    // stage 1: memory read in flight
    logic       t1_valid_reg;
    logic       t1_va0_reg;
    logic       t1_ua0_reg;
    logic       t1_same_reg;
    logic [7:0] t1_mu_reg;
    logic [7:0] t1_nu_reg;
    logic [7:0] t1_orow_reg;
    logic [7:0] t1_ocol_reg;

    // stage 2: corners and weights
    logic          t2_valid_reg;
    logic [PW-1:0] t2_px_reg [4];
    logic [WW-1:0] t2_w_reg  [4];
    logic [7:0]    t2_orow_reg;
    logic [7:0]    t2_ocol_reg;

    // stage 3: weighted channels
    logic          t3_valid_reg;
    logic [MW-1:0] t3_prod_reg [4][3];
    logic [7:0]    t3_orow_reg;
    logic [7:0]    t3_ocol_reg;

    logic       out_valid_reg;
    logic [7:0] out_row_reg;
    logic [7:0] out_col_reg;
    logic [7:0] out_ch_reg [3];

    logic          vbp;
    logic [PW-1:0] px_next [4];
    logic [8:0]    mc;
    logic [8:0]    nc;
    logic [WW-1:0] w_next  [4];
    logic [MW+1:0] acc     [3];

    always_comb
    begin
        vbp        = t1_same_reg ? t1_va0_reg : ~t1_va0_reg;
        px_next[0] = rd_data[{t1_va0_reg,  t1_ua0_reg}];
        px_next[1] = rd_data[{t1_va0_reg, ~t1_ua0_reg}];
        px_next[2] = rd_data[{vbp,  t1_ua0_reg}];
        px_next[3] = rd_data[{vbp, ~t1_ua0_reg}];
        mc         = 9'd256 - {1'b0, t1_mu_reg};
        nc         = 9'd256 - {1'b0, t1_nu_reg};
        w_next[0]  = WW'(mc * nc);
        w_next[1]  = WW'({1'b0, t1_mu_reg} * nc);
        w_next[2]  = WW'(mc * {1'b0, t1_nu_reg});
        w_next[3]  = WW'({1'b0, t1_mu_reg} * {1'b0, t1_nu_reg});
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            acc[ch] = (MW+2)'(32768) + (MW+2)'(t3_prod_reg[0][ch])
                    + (MW+2)'(t3_prod_reg[1][ch]) + (MW+2)'(t3_prod_reg[2][ch])
                    + (MW+2)'(t3_prod_reg[3][ch]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg  <= 1'b0;
            t2_valid_reg  <= 1'b0;
            t3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            t1_valid_reg  <= sample;
            t2_valid_reg  <= t1_valid_reg;
            t3_valid_reg  <= t2_valid_reg;
            out_valid_reg <= t3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_va0_reg  <= req.va[0];
            t1_ua0_reg  <= req.ua[0];
            t1_same_reg <= (req.va == req.vb);
            t1_mu_reg   <= req.mu;
            t1_nu_reg   <= req.nu;
            t1_orow_reg <= req.orow;
            t1_ocol_reg <= req.ocol;

            t2_orow_reg <= t1_orow_reg;
            t2_ocol_reg <= t1_ocol_reg;
            for (int k = 0; k < 4; k++)
            begin
                t2_px_reg[k] <= px_next[k];
                t2_w_reg[k]  <= w_next[k];
            end

            t3_orow_reg <= t2_orow_reg;
            t3_ocol_reg <= t2_ocol_reg;
            for (int k = 0; k < 4; k++)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    t3_prod_reg[k][ch] <= MW'(t2_px_reg[k][8*ch +: 8] * t2_w_reg[k]);
                end
            end

            out_row_reg <= t3_orow_reg;
            out_col_reg <= t3_ocol_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                out_ch_reg[ch] <= acc[ch][23:16];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_blue  = out_ch_reg[0];
    assign out_green = out_ch_reg[1];
    assign out_red   = out_ch_reg[2];

`ifndef SYNTH
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        t2_valid_reg |-> (18'(t2_w_reg[0]) + 18'(t2_w_reg[1]) + 18'(t2_w_reg[2])
                          + 18'(t2_w_reg[3])) == 18'd65536)
        else $error("bilinear weights do not sum to one");
`endif

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for panorama_to_cubemap_warp_unit: a clocked driver
// and monitor around a bit-true warp predictor (cube point, CORDIC, bilinear).
// Depends on pcw_pkg and the warp unit RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 60;
    localparam longint INV_GAIN_Q24 = 10188014;

    // atan(2^-i) in turns, 32 fractional bits
    localparam logic [31:0] ARC_TURNS [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    typedef struct {
        pcw_pkg::op_t op;
        logic [2:0] face;
        logic [5:0] frow;
        logic [5:0] fcol;
        logic [6:0] srow;
        logic [7:0] scol;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } req_t;

    typedef struct {
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    logic       clk, rst_n;
    logic       in_valid, in_stall;
    logic       operation;
    logic [2:0] face;
    logic [5:0] face_row, face_col;
    logic [6:0] src_row;
    logic [7:0] src_col, in_blue, in_green, in_red;
    logic       out_valid, out_stall;
    logic [7:0] out_row, out_col, out_blue, out_green, out_red;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    panorama_to_cubemap_warp_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .face(face), .face_row(face_row), .face_col(face_col),
        .src_row(src_row), .src_col(src_col),
        .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_row(out_row), .out_col(out_col),
        .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    req_t       pending_reqs[$];
    pix_t       expected_pix[$];
    logic [23:0] model_image [0:32767];
    bit         planned_written [0:32767];
    logic [6:0] model_width;
    int         gen_width;
    int         errors, cycles, accepted_cnt, samples_seen, writes_seen;
    int         queued_cnt;
    bit         quiet, hold_on, taken;
    int         send_gap, recv_gap;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint arc_step(int i);
        return (longint'(ARC_TURNS[i]) + 64'sd32768) >>> 16;
    endfunction

    // vectoring CORDIC: angle of (x, y) in turns (16 fractional bits), raw magnitude
    function automatic longint vec_angle(longint x, longint y, output longint mag);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            return 0;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 64'sd16384;
            end
            else
            begin
                x = -y; y = t; z = -64'sd16384;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += arc_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= arc_step(i);
            end
        end
        mag = x;
        return z;
    endfunction

    // source corners and weights for one cube-map pixel at face edge b
    function automatic void locate(int b, int fc, int fr, int fcl,
                                   output int ua, output int ub, output int va,
                                   output int vb, output longint mu, output longint nu);
        longint p, q, x, y, z, g, r, lon, lat, uf, vf, u8, v8, ui, vi, w, h;
        p = 2 * fr;
        q = 2 * fcl;
        case (fc)
            pcw_pkg::FACE_TOP:   begin x = p - b; y = q - b; z = b;     end
            pcw_pkg::FACE_LEFT:  begin x = q - b; y = -b;    z = b - p; end
            pcw_pkg::FACE_FRONT: begin x = b;     y = q - b; z = b - p; end
            pcw_pkg::FACE_RIGHT: begin x = b - q; y = b;     z = b - p; end
            pcw_pkg::FACE_BACK:  begin x = -b;    y = b - q; z = b - p; end
            default:             begin x = b - p; y = q - b; z = -b;    end
        endcase
        lon = vec_angle(x <<< 24, y <<< 24, g);
        r   = (g * INV_GAIN_Q24) >>> 24;
        lat = vec_angle(r, z <<< 24, g);
        uf = 4 * b * lon + ((2 * longint'(b)) <<< 16);
        vf = (longint'(b) <<< 16) - 4 * b * lat;
        u8 = (uf + 128) >>> 8;
        v8 = (vf + 128) >>> 8;
        ui = u8 >>> 8; mu = u8 - ui * 256;
        vi = v8 >>> 8; nu = v8 - vi * 256;
        w = 4 * b;
        h = 2 * b;
        ua = int'(((ui % w) + w) % w);
        ub = int'((ua + 1) % w);
        va = int'((vi < 0) ? 0 : ((vi > h - 1) ? h - 1 : vi));
        vb = int'((vi + 1 < 0) ? 0 : ((vi + 1 > h - 1) ? h - 1 : vi + 1));
    endfunction

    function automatic int clamp_width(int v);
        return (v < 1) ? 1 : ((v > 64) ? 64 : v);
    endfunction

    // apply one accepted transaction to the predictor
    function automatic void predict_warp(req_t t);
        int b, ua, ub, va, vb;
        longint mu, nu, acc;
        longint wt [4];
        logic [23:0] px [4];
        pix_t e;
        if (t.op == pcw_pkg::OP_WRITE)
        begin
            model_image[{t.srow, t.scol}] = {t.red, t.green, t.blue};
            return;
        end
        b = clamp_width(model_width);
        if (t.face > 5 || t.frow >= b || t.fcol >= b)
            return;
        locate(b, t.face, t.frow, t.fcol, ua, ub, va, vb, mu, nu);
        px[0] = model_image[va * 256 + ua];
        px[1] = model_image[va * 256 + ub];
        px[2] = model_image[vb * 256 + ua];
        px[3] = model_image[vb * 256 + ub];
        wt[0] = (256 - mu) * (256 - nu);
        wt[1] = mu * (256 - nu);
        wt[2] = (256 - mu) * nu;
        wt[3] = mu * nu;
        case (t.face)
            pcw_pkg::FACE_TOP:
            begin
                e.row = 8'(t.frow);         e.col = 8'(t.fcol + b);
            end
            pcw_pkg::FACE_DOWN:
            begin
                e.row = 8'(t.frow + 2 * b); e.col = 8'(t.fcol + b);
            end
            default:
            begin
                e.row = 8'(t.frow + b);     e.col = 8'(t.fcol + (t.face - 1) * b);
            end
        endcase
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 32768;
            for (int k = 0; k < 4; k++)
                acc += longint'((px[k] >> (8 * ch)) & 24'hFF) * wt[k];
            case (ch)
                0: e.blue  = 8'(acc >>> 16);
                1: e.green = 8'(acc >>> 16);
                default: e.red = 8'(acc >>> 16);
            endcase
        end
        expected_pix.push_back(e);
    endfunction

    task automatic queue_write(int r, int c);
        req_t t;
        t.op = pcw_pkg::OP_WRITE;
        t.face = 3'($urandom); t.frow = 6'($urandom); t.fcol = 6'($urandom);
        t.srow = 7'(r); t.scol = 8'(c);
        t.blue = 8'($urandom); t.green = 8'($urandom); t.red = 8'($urandom);
        planned_written[r * 256 + c] = 1'b1;
        pending_reqs.push_back(t);
        queued_cnt++;
    endtask

    // fill any unwritten corner first so the sample never reads an unwritten entry
    task automatic queue_sample(int fc, int fr, int fcl);
        req_t t;
        int ua, ub, va, vb;
        longint mu, nu;
        if (fc <= 5 && fr < gen_width && fcl < gen_width)
        begin
            locate(gen_width, fc, fr, fcl, ua, ub, va, vb, mu, nu);
            if (!planned_written[va * 256 + ua]) queue_write(va, ua);
            if (!planned_written[va * 256 + ub]) queue_write(va, ub);
            if (!planned_written[vb * 256 + ua]) queue_write(vb, ua);
            if (!planned_written[vb * 256 + ub]) queue_write(vb, ub);
        end
        t.op = pcw_pkg::OP_SAMPLE;
        t.face = 3'(fc); t.frow = 6'(fr); t.fcol = 6'(fcl);
        t.srow = 7'($urandom); t.scol = 8'($urandom);
        t.blue = 8'($urandom); t.green = 8'($urandom); t.red = 8'($urandom);
        pending_reqs.push_back(t);
        queued_cnt++;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_pix.size() != 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(int v);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 7'(v);
        @(negedge clk);
        cfg_we <= 1'b0;
        model_width = 7'(v);
        gen_width = clamp_width(v);
    endtask

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    endtask

    // driver: hold a stalled transaction, otherwise load the next or idle
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                send_gap <= $urandom_range(0, 16);
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                in_valid  <= 1'b1;
                operation <= pending_reqs[0].op;
                face      <= pending_reqs[0].face;
                face_row  <= pending_reqs[0].frow;
                face_col  <= pending_reqs[0].fcol;
                src_row   <= pending_reqs[0].srow;
                src_col   <= pending_reqs[0].scol;
                in_blue   <= pending_reqs[0].blue;
                in_green  <= pending_reqs[0].green;
                in_red    <= pending_reqs[0].red;
            end
            else
                in_valid <= 1'b0;
        end
        taken <= 1'b0;
        if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 15) == 0)
        begin
            recv_gap <= $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
            out_stall <= hold_on;
    end

    // acceptance and output monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles <= cycles + 1;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
            if (in_valid && !in_stall)
            begin
                if (pending_reqs[0].op == pcw_pkg::OP_WRITE)
                    writes_seen <= writes_seen + 1;
                predict_warp(pending_reqs.pop_front());
                accepted_cnt <= accepted_cnt + 1;
                taken <= 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                samples_seen <= samples_seen + 1;
                if (expected_pix.size() == 0)
                begin
                    errors++;
                    $display("unexpected result row %0d col %0d", out_row, out_col);
                end
                else
                begin
                    if (out_row   !== expected_pix[0].row)   report_mismatch("row", out_row, expected_pix[0].row);
                    if (out_col   !== expected_pix[0].col)   report_mismatch("col", out_col, expected_pix[0].col);
                    if (out_blue  !== expected_pix[0].blue)  report_mismatch("blue", out_blue, expected_pix[0].blue);
                    if (out_green !== expected_pix[0].green) report_mismatch("green", out_green, expected_pix[0].green);
                    if (out_red   !== expected_pix[0].red)   report_mismatch("red", out_red, expected_pix[0].red);
                    void'(expected_pix.pop_front());
                end
            end
        end
    end

    // long receiver hold-off so the pipeline fills and backs up
    initial
    begin
        hold_on = 1'b0;
        wait (accepted_cnt > 300);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
    end

    initial
    begin
        int widths [9] = '{1, 0, 127, 2, 5, 17, 33, 40, 64};
        int counted, sel;
        rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
        operation = pcw_pkg::OP_WRITE; face = '0; face_row = '0; face_col = '0;
        src_row = '0; src_col = '0; in_blue = '0; in_green = '0; in_red = '0;
        errors = 0; cycles = 0; accepted_cnt = 0; samples_seen = 0; writes_seen = 0;
        queued_cnt = 0;
        quiet = 1'b0; taken = 1'b0; send_gap = 0; recv_gap = 0;
        model_width = 7'd64; gen_width = 64;
        foreach (planned_written[i]) planned_written[i] = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: memory corners, every face, top and down centers, bad samples
        queue_write(0, 0);
        queue_write(127, 255);
        pending_reqs[$].blue = 8'hFF; pending_reqs[$].green = 8'hFF; pending_reqs[$].red = 8'hFF;
        pending_reqs[0].blue = 8'h00; pending_reqs[0].green = 8'h00; pending_reqs[0].red = 8'h00;
        queue_sample(pcw_pkg::FACE_TOP, 32, 32);
        queue_sample(pcw_pkg::FACE_DOWN, 32, 32);
        queue_sample(pcw_pkg::FACE_TOP, 0, 0);
        queue_sample(pcw_pkg::FACE_LEFT, 63, 0);
        queue_sample(pcw_pkg::FACE_FRONT, 0, 63);
        queue_sample(pcw_pkg::FACE_RIGHT, 63, 63);
        queue_sample(pcw_pkg::FACE_BACK, 31, 0);
        queue_sample(pcw_pkg::FACE_BACK, 31, 63);
        queue_sample(pcw_pkg::FACE_DOWN, 63, 63);
        queue_sample(6, 1, 1);
        queue_sample(7, 63, 63);

        foreach (widths[k])
        begin
            set_width(widths[k]);
            if (k == 8)
                quiet = 1'b1;
            counted = queued_cnt;
            queue_sample(pcw_pkg::FACE_FRONT, 63, 63);
            while (queued_cnt - counted < 160)
            begin
                wait (pending_reqs.size() < 32);
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    queue_write($urandom_range(0, 127), $urandom_range(0, 255));
                else if (sel == 1)
                    queue_sample($urandom_range(0, 7), $urandom_range(0, 63),
                                 $urandom_range(0, 63));
                else
                    queue_sample($urandom_range(0, 5), $urandom_range(0, gen_width - 1),
                                 $urandom_range(0, gen_width - 1));
            end
        end

        wait_drained();
        $display("covered %0d accepted transactions: %0d pixel writes, %0d warped samples",
                 accepted_cnt, writes_seen, samples_seen);
        $display("face widths swept from 0 to 127 with input and output back-pressure");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
